@@ design/imu_stroke_grid_tracker_top_assert.svh @@
// Assertion macros for the stroke grid tracker.
// Included by the top level, which checks its own logic; depends on nothing else.
`ifndef IMU_STROKE_GRID_TRACKER_TOP_ASSERT_SVH
`define IMU_STROKE_GRID_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ISGT_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("stroke grid tracker assertion failed");
`define ISGT_ASSERT(lbl, prop) `ISGT_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define ISGT_ASSERT_CLK(lbl, clk, rstn, prop)
`define ISGT_ASSERT(lbl, prop)
`endif
`endif

@@ design/isgt_pkg.sv @@
// Shared types and constants of the stroke grid tracker.
// Used by the controller, the datapath and the top level.
`default_nettype none
package isgt_pkg;

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_EMA_ALPHA  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DAMPING    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ONSET_TH   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_OFFSET_TH  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ONSET_N    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_OFFSET_N   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_RANGE      = 3'd6;
  localparam logic [CFG_IW-1:0] REG_STABLE_MS  = 3'd7;

  localparam logic [15:0] RST_EMA_ALPHA = 16'd19661;
  localparam logic [15:0] RST_DAMPING   = 16'd52429;
  localparam logic [14:0] RST_ONSET_TH  = 15'd1229;
  localparam logic [14:0] RST_OFFSET_TH = 15'd410;
  localparam logic [7:0]  RST_ONSET_N   = 8'd3;
  localparam logic [7:0]  RST_OFFSET_N  = 8'd5;
  localparam logic [14:0] RST_RANGE     = 15'd8192;
  localparam logic [15:0] RST_STABLE_MS = 16'd500;

  localparam logic [15:0] ONE_G = 16'd4096;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_SQRT,
    OP_REST,
    OP_DIV,
    OP_DETECT,
    OP_EMA1,
    OP_EMA2,
    OP_BL1,
    OP_BL2,
    OP_CELL0,
    OP_CFIN,
    OP_DONE,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] idx;
    logic [1:0] axis;
  } ctrl_t;

  typedef struct packed {
    logic rest_go;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ design/isgt_ctrl.sv @@
// Sequencer of the stroke grid tracker: steps the datapath through one command.
// Depends on isgt_pkg.
`default_nettype none
module isgt_ctrl #(
  parameter int GRID_HALF = 5
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     cmd_i,
  output logic                in_stall_o,
  input  wire isgt_pkg::stat_t stat_i,
  output isgt_pkg::ctrl_t     ctrl_o
);

  localparam int QB = $clog2(GRID_HALF + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_SQRT   = 4'd2;
  localparam logic [3:0] S_REST   = 4'd3;
  localparam logic [3:0] S_RDIV   = 4'd4;
  localparam logic [3:0] S_DETECT = 4'd5;
  localparam logic [3:0] S_EMA1   = 4'd6;
  localparam logic [3:0] S_EMA2   = 4'd7;
  localparam logic [3:0] S_BL1    = 4'd8;
  localparam logic [3:0] S_BL2    = 4'd9;
  localparam logic [3:0] S_CELL0  = 4'd10;
  localparam logic [3:0] S_CDIV   = 4'd11;
  localparam logic [3:0] S_CFIN   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] axis_q, axis_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    ctrl_o.op   = isgt_pkg::OP_NONE;
    ctrl_o.idx  = cnt_q;
    ctrl_o.axis = axis_q;
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.op = isgt_pkg::OP_LOAD;
          axis_d    = 2'd0;
          state_d   = (cmd_i == isgt_pkg::CMD_SAMPLE) ? S_SQ : S_DONE;
        end
      end
      S_SQ: begin
        ctrl_o.op = isgt_pkg::OP_SQ;
        if (axis_q == 2'd2) begin
          axis_d  = 2'd0;
          cnt_d   = 4'd15;
          state_d = S_SQRT;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_SQRT: begin
        ctrl_o.op = isgt_pkg::OP_SQRT;
        if (cnt_q == 4'd0) begin
          state_d = S_REST;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_REST: begin
        ctrl_o.op = isgt_pkg::OP_REST;
        cnt_d     = 4'd15;
        state_d   = stat_i.rest_go ? S_RDIV : S_DETECT;
      end
      S_RDIV: begin
        ctrl_o.op = isgt_pkg::OP_DIV;
        if (cnt_q == 4'd0) begin
          state_d = S_DETECT;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_DETECT: begin
        ctrl_o.op = isgt_pkg::OP_DETECT;
        axis_d    = 2'd0;
        state_d   = S_EMA1;
      end
      S_EMA1: begin
        ctrl_o.op = isgt_pkg::OP_EMA1;
        state_d   = S_EMA2;
      end
      S_EMA2: begin
        ctrl_o.op = isgt_pkg::OP_EMA2;
        state_d   = S_BL1;
      end
      S_BL1: begin
        ctrl_o.op = isgt_pkg::OP_BL1;
        state_d   = S_BL2;
      end
      S_BL2: begin
        ctrl_o.op = isgt_pkg::OP_BL2;
        state_d   = S_CELL0;
      end
      S_CELL0: begin
        ctrl_o.op = isgt_pkg::OP_CELL0;
        cnt_d     = 4'(QB - 1);
        state_d   = S_CDIV;
      end
      S_CDIV: begin
        ctrl_o.op = isgt_pkg::OP_DIV;
        if (cnt_q == 4'd0) begin
          state_d = S_CFIN;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_CFIN: begin
        ctrl_o.op = isgt_pkg::OP_CFIN;
        if (axis_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_EMA1;
        end
      end
      S_DONE: begin
        ctrl_o.op = isgt_pkg::OP_DONE;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          ctrl_o.op = isgt_pkg::OP_OUT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 4'd0;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

endmodule
`default_nettype wire

@@ design/isgt_dp.sv @@
// Datapath of the stroke grid tracker: configuration, tracker state, the shared
// square-root and divider steps, the filters and the output register. Depends on isgt_pkg.
`default_nettype none
module isgt_dp #(
  parameter int COOLDOWN_SAMPLES = 10,
  parameter int REST_SAMPLES     = 5,
  parameter int SAMPLE_LIMIT     = 256,
  parameter int TRAJ_MAX         = 64,
  parameter int TRAJ_MIN         = 3,
  parameter int GRID_HALF        = 5
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [isgt_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [isgt_pkg::CFG_DW-1:0] cfg_data_i,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic signed [15:0]          accel_x_i,
  input  wire logic signed [15:0]          accel_y_i,
  input  wire logic signed [15:0]          accel_z_i,
  input  wire isgt_pkg::ctrl_t             ctrl_i,
  output isgt_pkg::stat_t                  stat_o,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic [3:0]                       cell_x_o,
  output logic [3:0]                       cell_y_o,
  output logic [3:0]                       cell_z_o,
  output logic                             cell_changed_o,
  output logic                             moved_flag_o,
  output logic                             has_movement_o,
  output logic                             stroke_active_o,
  output logic                             stroke_complete_o,
  output logic [8:0]                       onset_index_o,
  output logic [8:0]                       offset_index_o,
  output logic                             stable_o,
  output logic [6:0]                       trajectory_length_o
);

  localparam int SCW  = $clog2(SAMPLE_LIMIT + 1);
  localparam int KW   = $clog2(REST_SAMPLES + 1);
  localparam int QB   = $clog2(GRID_HALF + 1);
  localparam int CW   = $clog2(2 * GRID_HALF + 1);
  localparam int TW   = $clog2(TRAJ_MAX + 1);
  localparam int RMW  = 16 + QB;
  localparam int CMPW = RMW + 16;
  localparam int NUMW = 33 + QB;
  localparam int ACCW = 50;

  logic [15:0] alpha_q, damp_q, stab_q;
  logic [14:0] onth_q, offth_q, range_q;
  logic [7:0]  onsm_q, offsm_q;

  logic [1:0]         cmd_q;
  logic signed [15:0] ain_q [3];
  logic [31:0]        sq_rem_q, sq_res_q;
  logic [RMW-1:0]     dv_rem_q;
  logic [14:0]        dv_dvs_q;
  logic [15:0]        dv_quo_q;
  logic               dv_neg_q, ovf_q, rest_go_q, rest_fin_q, changed_q;
  logic signed [ACCW-1:0] acc_q;

  logic [SCW-1:0]     sc_q, onpos_q, offpos_q;
  logic [15:0]        rest_q, idle_q;
  logic               rest_done_q, active_q, complete_q, moved_q;
  logic [7:0]         onrun_q, offrun_q;
  logic [TW-1:0]      pts_q;
  logic signed [31:0] filt_q [3];
  logic signed [31:0] pos_q [3];
  logic [CW-1:0]      cell_q [3];
  logic               out_valid_q;

  logic signed [15:0] a_cur;
  logic signed [31:0] filt_cur, pos_cur, sq_prod;
  logic [31:0]        sq_bit, sq_try;
  logic               sq_ge;
  logic [CMPW-1:0]    dv_sh;
  logic               dv_ge;
  logic [SCW-1:0]     sc_inc;
  logic [31:0]        k32;
  logic               rest_cond, rest_go, rest_fin;
  logic [15:0]        mag, rest_new, dev;
  logic               done_new;
  logic [7:0]         onrun_inc, offrun_inc;
  logic [16:0]        ialpha, idamp;
  logic signed [32:0] prod_a;
  logic signed [48:0] prod_d;
  logic signed [ACCW-1:0] mul_ef, mul_dp, sum_e, sum_b;
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]    n_abs, npr;
  logic [14:0]        rng;
  logic [RMW-1:0]     nq;
  logic               ovf_new;
  logic [CW-1:0]      qm, cell_new;

  always_comb begin
    a_cur    = ain_q[ctrl_i.axis];
    filt_cur = filt_q[ctrl_i.axis];
    pos_cur  = pos_q[ctrl_i.axis];
    sq_prod  = a_cur * a_cur;
    sq_bit   = 32'(1) << {ctrl_i.idx, 1'b0};
    sq_try   = sq_res_q + sq_bit;
    sq_ge    = sq_rem_q >= sq_try;
    dv_sh    = CMPW'(dv_dvs_q) << ctrl_i.idx;
    dv_ge    = CMPW'(dv_rem_q) >= dv_sh;

    sc_inc    = (32'(sc_q) < 32'(SAMPLE_LIMIT)) ? sc_q + SCW'(1) : sc_q;
    k32       = 32'(sc_inc) - 32'(COOLDOWN_SAMPLES);
    rest_cond = (32'(sc_inc) > 32'(COOLDOWN_SAMPLES)) && !rest_done_q;
    rest_go   = rest_cond && (k32 <= 32'(REST_SAMPLES));
    rest_fin  = rest_cond && (k32 == 32'(REST_SAMPLES));
    mag       = sq_res_q[15:0];

    rest_new = rest_q;
    if (rest_go_q) begin
      rest_new = dv_neg_q ? rest_q - dv_quo_q : rest_q + dv_quo_q;
    end
    done_new   = rest_done_q | rest_fin_q;
    dev        = (mag > rest_new) ? mag - rest_new : rest_new - mag;
    onrun_inc  = (onrun_q == 8'd255) ? onrun_q : onrun_q + 8'd1;
    offrun_inc = (offrun_q == 8'd255) ? offrun_q : offrun_q + 8'd1;

    ialpha = 17'(17'd65536 - {1'b0, alpha_q});
    idamp  = 17'(17'd65536 - {1'b0, damp_q});
    prod_a = $signed({1'b0, alpha_q}) * a_cur;
    prod_d = $signed({1'b0, damp_q}) * pos_cur;
    mul_ef = $signed({1'b0, ialpha}) * filt_cur;
    mul_dp = $signed({1'b0, idamp}) * filt_cur;
    sum_e  = acc_q + mul_ef;
    sum_b  = acc_q + mul_dp;

    num     = NUMW'(pos_cur) * NUMW'(GRID_HALF);
    n_abs   = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    rng     = (range_q == 15'd0) ? 15'd1 : range_q;
    npr     = n_abs + (NUMW'(rng) << 15);
    nq      = RMW'(npr >> 16);
    ovf_new = CMPW'(nq) >= (CMPW'(rng) << QB);

    qm = (ovf_q || (32'(dv_quo_q) > 32'(GRID_HALF))) ? CW'(GRID_HALF) : CW'(dv_quo_q);
    cell_new = dv_neg_q ? CW'(GRID_HALF) - qm : CW'(GRID_HALF) + qm;

    stat_o.rest_go  = rest_go;
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= isgt_pkg::RST_EMA_ALPHA;
      damp_q  <= isgt_pkg::RST_DAMPING;
      onth_q  <= isgt_pkg::RST_ONSET_TH;
      offth_q <= isgt_pkg::RST_OFFSET_TH;
      onsm_q  <= isgt_pkg::RST_ONSET_N;
      offsm_q <= isgt_pkg::RST_OFFSET_N;
      range_q <= isgt_pkg::RST_RANGE;
      stab_q  <= isgt_pkg::RST_STABLE_MS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        isgt_pkg::REG_EMA_ALPHA: alpha_q <= cfg_data_i;
        isgt_pkg::REG_DAMPING:   damp_q  <= cfg_data_i;
        isgt_pkg::REG_ONSET_TH:  onth_q  <= cfg_data_i[14:0];
        isgt_pkg::REG_OFFSET_TH: offth_q <= cfg_data_i[14:0];
        isgt_pkg::REG_ONSET_N:   onsm_q  <= cfg_data_i[7:0];
        isgt_pkg::REG_OFFSET_N:  offsm_q <= cfg_data_i[7:0];
        isgt_pkg::REG_RANGE:     range_q <= cfg_data_i[14:0];
        isgt_pkg::REG_STABLE_MS: stab_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      isgt_pkg::OP_LOAD: begin
        cmd_q    <= cmd_i;
        ain_q[0] <= accel_x_i;
        ain_q[1] <= accel_y_i;
        ain_q[2] <= accel_z_i;
        sq_rem_q <= 32'd0;
        sq_res_q <= 32'd0;
      end
      isgt_pkg::OP_SQ: begin
        sq_rem_q <= sq_rem_q + 32'(sq_prod);
      end
      isgt_pkg::OP_SQRT: begin
        if (sq_ge) begin
          sq_rem_q <= sq_rem_q - sq_try;
          sq_res_q <= (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
      end
      isgt_pkg::OP_REST: begin
        rest_go_q  <= rest_go;
        rest_fin_q <= rest_fin;
        dv_neg_q   <= mag < rest_q;
        dv_rem_q   <= RMW'((mag >= rest_q) ? mag - rest_q : rest_q - mag);
        dv_dvs_q   <= 15'(k32[KW-1:0]);
        dv_quo_q   <= 16'd0;
      end
      isgt_pkg::OP_DIV: begin
        if (dv_ge) begin
          dv_rem_q <= dv_rem_q - dv_sh[RMW-1:0];
          dv_quo_q[ctrl_i.idx] <= 1'b1;
        end
      end
      isgt_pkg::OP_EMA1: acc_q <= (ACCW'(prod_a) <<< 16) + ACCW'(32768);
      isgt_pkg::OP_BL1:  acc_q <= ACCW'(prod_d) + ACCW'(32768);
      isgt_pkg::OP_CELL0: begin
        dv_neg_q <= num[NUMW-1];
        dv_rem_q <= nq;
        dv_dvs_q <= rng;
        dv_quo_q <= 16'd0;
        ovf_q    <= ovf_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= '0;
      rest_q      <= isgt_pkg::ONE_G;
      rest_done_q <= 1'b0;
      active_q    <= 1'b0;
      complete_q  <= 1'b0;
      onrun_q     <= 8'd0;
      offrun_q    <= 8'd0;
      onpos_q     <= '0;
      offpos_q    <= '0;
      pts_q       <= TW'(1);
      moved_q     <= 1'b0;
      idle_q      <= 16'd0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        filt_q[i] <= 32'sd0;
        pos_q[i]  <= 32'sd0;
        cell_q[i] <= CW'(GRID_HALF);
      end
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctrl_i.op)
        isgt_pkg::OP_LOAD: changed_q <= 1'b0;
        isgt_pkg::OP_REST: sc_q <= sc_inc;
        isgt_pkg::OP_DETECT: begin
          rest_q      <= rest_new;
          rest_done_q <= done_new;
          if (done_new) begin
            if (!active_q && !complete_q) begin
              if (32'(dev) > 32'(onth_q)) begin
                onrun_q <= onrun_inc;
                if (onrun_inc >= onsm_q) begin
                  active_q <= 1'b1;
                  onpos_q  <= (32'(sc_q) > 32'(onsm_q)) ? SCW'(32'(sc_q) - 32'(onsm_q)) : '0;
                end
              end else begin
                onrun_q <= 8'd0;
              end
            end else if (active_q && !complete_q) begin
              if (32'(dev) < 32'(offth_q)) begin
                offrun_q <= offrun_inc;
                if (offrun_inc >= offsm_q) begin
                  active_q   <= 1'b0;
                  complete_q <= 1'b1;
                  offpos_q   <= (32'(sc_q) > 32'(offsm_q)) ?
                                SCW'(32'(sc_q) - 32'(offsm_q)) : sc_q;
                end
              end else begin
                offrun_q <= 8'd0;
              end
            end
          end
        end
        isgt_pkg::OP_EMA2: filt_q[ctrl_i.axis] <= sum_e[47:16];
        isgt_pkg::OP_BL2:  pos_q[ctrl_i.axis]  <= sum_b[47:16];
        isgt_pkg::OP_CFIN: begin
          cell_q[ctrl_i.axis] <= cell_new;
          if (cell_new != cell_q[ctrl_i.axis]) begin
            changed_q <= 1'b1;
          end
        end
        isgt_pkg::OP_DONE: begin
          unique case (cmd_q)
            isgt_pkg::CMD_SAMPLE: begin
              if (changed_q) begin
                if (32'(pts_q) < 32'(TRAJ_MAX)) begin
                  pts_q <= pts_q + TW'(1);
                end
                moved_q <= 1'b1;
                idle_q  <= 16'd0;
              end
            end
            isgt_pkg::CMD_TICK: begin
              if (idle_q != 16'hFFFF) begin
                idle_q <= idle_q + 16'd1;
              end
            end
            isgt_pkg::CMD_RESTART: begin
              sc_q        <= '0;
              rest_q      <= isgt_pkg::ONE_G;
              rest_done_q <= 1'b0;
              active_q    <= 1'b0;
              complete_q  <= 1'b0;
              onrun_q     <= 8'd0;
              offrun_q    <= 8'd0;
              onpos_q     <= '0;
              offpos_q    <= '0;
              pts_q       <= TW'(1);
              moved_q     <= 1'b0;
              idle_q      <= 16'd0;
              for (int i = 0; i < 3; i++) begin
                filt_q[i] <= 32'sd0;
                pos_q[i]  <= 32'sd0;
                cell_q[i] <= CW'(GRID_HALF);
              end
            end
            isgt_pkg::CMD_CLEAR: begin
              pts_q   <= TW'(1);
              moved_q <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        isgt_pkg::OP_OUT: out_valid_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == isgt_pkg::OP_OUT) begin
      cell_x_o            <= 4'(cell_q[0]);
      cell_y_o            <= 4'(cell_q[1]);
      cell_z_o            <= 4'(cell_q[2]);
      cell_changed_o      <= changed_q;
      moved_flag_o        <= moved_q;
      has_movement_o      <= moved_q && (32'(pts_q) > 32'(TRAJ_MIN));
      stroke_active_o     <= active_q;
      stroke_complete_o   <= complete_q;
      onset_index_o       <= 9'(onpos_q);
      offset_index_o      <= 9'(offpos_q);
      stable_o            <= idle_q >= stab_q;
      trajectory_length_o <= 7'(pts_q);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ design/imu_stroke_grid_tracker_top.sv @@
// Top level of the accelerometer stroke grid tracker.
// Joins isgt_ctrl and isgt_dp; depends on isgt_pkg and the assertion header.
//
// Usage: one command per input transfer (sample, millisecond tick, restart or
// clear trajectory). Each command yields exactly one result transfer that shows
// the tracker state after the command. A sample passes through the
// one-bit-per-cycle square root, the restoring divider for the rest mean and
// the per-axis cell quotient, all in one shared datapath; other commands skip
// these steps and go straight to the result.
// The block holds one command at a time; in_stall_o is high while it works.
// The next command is taken while the previous result still waits in the
// output register. When out_stall_i holds a result, the block finishes the
// next command and then waits for the output register to drain.
// Reset restores the default configuration and the reset tracker state;
// no clearing pass is needed. Configuration transfers are always taken.
`default_nettype none
`include "imu_stroke_grid_tracker_top_assert.svh"
module imu_stroke_grid_tracker_top #(
  parameter int COOLDOWN_SAMPLES = 10,
  parameter int REST_SAMPLES     = 5,
  parameter int SAMPLE_LIMIT     = 256,
  parameter int TRAJ_MAX         = 64,
  parameter int TRAJ_MIN         = 3,
  parameter int GRID_HALF        = 5
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic signed [15:0]          accel_x_i,
  input  wire logic signed [15:0]          accel_y_i,
  input  wire logic signed [15:0]          accel_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [3:0]                       cell_x_o,
  output logic [3:0]                       cell_y_o,
  output logic [3:0]                       cell_z_o,
  output logic                             cell_changed_o,
  output logic                             moved_flag_o,
  output logic                             has_movement_o,
  output logic                             stroke_active_o,
  output logic                             stroke_complete_o,
  output logic [8:0]                       onset_index_o,
  output logic [8:0]                       offset_index_o,
  output logic                             stable_o,
  output logic [6:0]                       trajectory_length_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [isgt_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [isgt_pkg::CFG_DW-1:0] cfg_data_i
);

  isgt_pkg::ctrl_t ctrl;
  isgt_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  isgt_ctrl #(
    .GRID_HALF(GRID_HALF)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .cmd_i     (cmd_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  isgt_dp #(
    .COOLDOWN_SAMPLES(COOLDOWN_SAMPLES),
    .REST_SAMPLES    (REST_SAMPLES),
    .SAMPLE_LIMIT    (SAMPLE_LIMIT),
    .TRAJ_MAX        (TRAJ_MAX),
    .TRAJ_MIN        (TRAJ_MIN),
    .GRID_HALF       (GRID_HALF)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd_i),
    .accel_x_i          (accel_x_i),
    .accel_y_i          (accel_y_i),
    .accel_z_i          (accel_z_i),
    .ctrl_i             (ctrl),
    .stat_o             (stat),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .cell_x_o           (cell_x_o),
    .cell_y_o           (cell_y_o),
    .cell_z_o           (cell_z_o),
    .cell_changed_o     (cell_changed_o),
    .moved_flag_o       (moved_flag_o),
    .has_movement_o     (has_movement_o),
    .stroke_active_o    (stroke_active_o),
    .stroke_complete_o  (stroke_complete_o),
    .onset_index_o      (onset_index_o),
    .offset_index_o     (offset_index_o),
    .stable_o           (stable_o),
    .trajectory_length_o(trajectory_length_o)
  );

  `ISGT_ASSERT(a_stroke_flags_exclusive, out_valid_o |-> !(stroke_active_o && stroke_complete_o))
  `ISGT_ASSERT(a_change_sets_moved, (out_valid_o && cell_changed_o) |-> moved_flag_o)
  `ISGT_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `ISGT_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(in_stall_o))

endmodule
`default_nettype wire

@@ dv/imu_stroke_grid_tracker_top_test.sv @@
// Self-checking testbench for the accelerometer stroke grid tracker top level.
// Predicts every result from its own model of the tracker; depends on isgt_pkg and the RTL.
`timescale 1ns / 100ps
module imu_stroke_grid_tracker_top_test;
  import isgt_pkg::*;

  localparam int COOLDOWN = 10;
  localparam int REST_N = 5;
  localparam int SAMPLE_MAX = 256;
  localparam int TRAJ_MAX = 64;
  localparam int TRAJ_MIN = 3;
  localparam int HALF = 5;
  localparam int SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } command_t;

  typedef struct packed {
    logic [3:0] cx;
    logic [3:0] cy;
    logic [3:0] cz;
    logic changed;
    logic moved;
    logic has_move;
    logic active;
    logic complete;
    logic [8:0] onset;
    logic [8:0] offset;
    logic stable;
    logic [6:0] traj_len;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = CMD_TICK;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] cell_x_o, cell_y_o, cell_z_o;
  logic cell_changed_o, moved_flag_o, has_movement_o, stroke_active_o, stroke_complete_o;
  logic [8:0] onset_index_o, offset_index_o;
  logic stable_o;
  logic [6:0] trajectory_length_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  imu_stroke_grid_tracker_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor configuration and state.
  logic [15:0] alpha_q, damp_q, stable_lim;
  logic [14:0] on_th, off_th, range_q;
  logic [7:0] on_need, off_need;
  longint filt[3], pos[3];
  int cells[3];
  int n_samples, rest_lvl, stroke_st, on_run, off_run, on_at, off_at, points, idle_cnt;
  bit rest_ok, moved;

  command_t pending_cmds[$];
  status_t expected_status[$];
  int send_idle_pct, recv_idle_pct, errors, mismatches, hold_cycles;
  bit send_pause;
  longint cycles;

  function automatic longint round_q16(longint p);
    longint v;
    v = p + 32768;
    if (v >= 0) return v / 65536;
    return -((-v + 65535) / 65536);
  endfunction

  function automatic int grid_cell(longint p);
    longint num, d, n, q, c;
    num = p * HALF;
    d = longint'(range_q == 0 ? 1 : range_q) * 65536;
    n = num < 0 ? -num : num;
    q = (2 * n + d) / (2 * d);
    c = (num < 0 ? -q : q) + HALF;
    if (c < 0) c = 0;
    if (c > 2 * HALF) c = 2 * HALF;
    return int'(c);
  endfunction

  function automatic int mag_floor(longint sq);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= sq) r = r + 1;
    return int'(r);
  endfunction

  task automatic restart_tracker();
    for (int i = 0; i < 3; i++) begin
      filt[i] = 0;
      pos[i] = 0;
      cells[i] = HALF;
    end
    n_samples = 0; rest_lvl = 4096; rest_ok = 0; stroke_st = 0;
    on_run = 0; off_run = 0; on_at = 0; off_at = 0; points = 1; moved = 0; idle_cnt = 0;
  endtask

  task automatic apply_register(logic [CFG_IW-1:0] idx, logic [15:0] v);
    case (idx)
      REG_EMA_ALPHA: alpha_q = v;
      REG_DAMPING:   damp_q = v;
      REG_ONSET_TH:  on_th = v[14:0];
      REG_OFFSET_TH: off_th = v[14:0];
      REG_ONSET_N:   on_need = v[7:0];
      REG_OFFSET_N:  off_need = v[7:0];
      REG_RANGE:     range_q = v[14:0];
      default:       stable_lim = v;
    endcase
  endtask

  task automatic track_command(command_t c);
    status_t s;
    longint a[3];
    longint sq;
    int mg, k, dev, nc;
    bit chg;
    chg = 0;
    case (c.cmd)
      CMD_SAMPLE: begin
        a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
        if (n_samples < SAMPLE_MAX) n_samples++;
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        mg = mag_floor(sq);
        if (n_samples > COOLDOWN && !rest_ok) begin
          k = n_samples - COOLDOWN;
          if (k <= REST_N) rest_lvl = rest_lvl + (mg - rest_lvl) / k;
          if (k == REST_N) rest_ok = 1;
        end
        if (rest_ok) begin
          dev = mg > rest_lvl ? mg - rest_lvl : rest_lvl - mg;
          if (stroke_st == 0) begin
            if (dev > on_th) begin
              if (on_run < 255) on_run++;
              if (on_run >= on_need) begin
                stroke_st = 1;
                on_at = n_samples > on_need ? n_samples - on_need : 0;
              end
            end else on_run = 0;
          end else if (stroke_st == 1) begin
            if (dev < off_th) begin
              if (off_run < 255) off_run++;
              if (off_run >= off_need) begin
                stroke_st = 2;
                off_at = n_samples > off_need ? n_samples - off_need : n_samples;
              end
            end else off_run = 0;
          end
        end
        for (int i = 0; i < 3; i++) begin
          filt[i] = round_q16(longint'(alpha_q) * (a[i] * 65536)
                              + longint'(65536 - alpha_q) * filt[i]);
          pos[i] = round_q16(longint'(damp_q) * pos[i] + longint'(65536 - damp_q) * filt[i]);
          nc = grid_cell(pos[i]);
          if (nc != cells[i]) chg = 1;
          cells[i] = nc;
        end
        if (chg) begin
          if (points < TRAJ_MAX) points++;
          moved = 1;
          idle_cnt = 0;
        end
      end
      CMD_TICK: if (idle_cnt < 65535) idle_cnt++;
      CMD_RESTART: restart_tracker();
      default: begin
        points = 1;
        moved = 0;
      end
    endcase
    s.cx = cells[0]; s.cy = cells[1]; s.cz = cells[2];
    s.changed = chg; s.moved = moved; s.has_move = moved && points > TRAJ_MIN;
    s.active = stroke_st == 1; s.complete = stroke_st == 2;
    s.onset = on_at; s.offset = off_at;
    s.stable = idle_cnt >= stable_lim; s.traj_len = points;
    expected_status.push_back(s);
  endtask

  // Stimulus driver.
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i) track_command('{cmd_i, accel_x_i, accel_y_i, accel_z_i});
      if (!send_pause && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        command_t c;
        c = pending_cmds.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= c.cmd; accel_x_i <= c.ax; accel_y_i <= c.ay; accel_z_i <= c.az;
      end else in_valid_i <= 1'b0;
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin
    status_t got, want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{cell_x_o, cell_y_o, cell_z_o, cell_changed_o, moved_flag_o, has_movement_o,
                stroke_active_o, stroke_complete_o, onset_index_o, offset_index_o,
                stable_o, trajectory_length_o};
        if (expected_status.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result transfer %p", got);
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else out_stall_i <= $urandom_range(99) < recv_idle_pct;
    end
  end

  task automatic write_register(logic [CFG_IW-1:0] idx, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid_i || expected_status.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic command_t make_sample(int x, int y, int z);
    return '{CMD_SAMPLE, 16'(x), 16'(y), 16'(z)};
  endfunction

  task automatic queue_random(int count);
    int r, g;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 3) pending_cmds.push_back('{CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom)});
      else if (r < 6) pending_cmds.push_back('{CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom)});
      else if (r < 18) pending_cmds.push_back('{CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom)});
      else if (r < 28) pending_cmds.push_back(make_sample($urandom, $urandom, $urandom));
      else begin
        g = ($urandom_range(3) == 0) ? 12000 : 1500;
        pending_cmds.push_back(make_sample($urandom_range(2 * g) - g, $urandom_range(2 * g) - g,
                                           4096 + $urandom_range(2 * g) - g));
      end
    end
  endtask

  task automatic queue_stroke();
    pending_cmds.push_back('{CMD_RESTART, 16'h0, 16'h0, 16'h0});
    repeat (15) pending_cmds.push_back(make_sample(0, 0, 4096));
    repeat (4) pending_cmds.push_back(make_sample(9000, -9000, 4096));
    repeat (7) pending_cmds.push_back(make_sample(0, 0, 4096));
  endtask

  initial begin
    cycles = 0; errors = 0; mismatches = 0; hold_cycles = 0; send_pause = 0;
    send_idle_pct = 13; recv_idle_pct = 59;
    apply_register(REG_EMA_ALPHA, RST_EMA_ALPHA);
    apply_register(REG_DAMPING, RST_DAMPING);
    apply_register(REG_ONSET_TH, RST_ONSET_TH);
    apply_register(REG_OFFSET_TH, RST_OFFSET_TH);
    apply_register(REG_ONSET_N, RST_ONSET_N);
    apply_register(REG_OFFSET_N, RST_OFFSET_N);
    apply_register(REG_RANGE, RST_RANGE);
    apply_register(REG_STABLE_MS, RST_STABLE_MS);
    restart_tracker();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pending_cmds.push_back(make_sample(32767, -32768, 0));
    pending_cmds.push_back(make_sample(-32768, 32767, -32768));
    pending_cmds.push_back(make_sample(0, 0, 0));
    pending_cmds.push_back('{CMD_TICK, 16'hFFFF, 16'h0, 16'h0});
    pending_cmds.push_back('{CMD_CLEAR, 16'h0, 16'hFFFF, 16'h0});
    queue_stroke();
    pending_cmds.push_back('{CMD_TICK, 16'h0, 16'h0, 16'hFFFF});
    wait_drained();

    write_register(REG_EMA_ALPHA, 16'hFFFF);
    write_register(REG_DAMPING, 16'h0000);
    write_register(REG_ONSET_TH, 16'h0000);
    write_register(REG_OFFSET_TH, 16'h7FFF);
    write_register(REG_ONSET_N, 16'h0000);
    write_register(REG_OFFSET_N, 16'h0001);
    write_register(REG_RANGE, 16'h0000);
    write_register(REG_STABLE_MS, 16'h0000);
    queue_stroke();
    queue_random(200);
    wait_drained();

    write_register(REG_EMA_ALPHA, 16'h0000);
    write_register(REG_DAMPING, 16'hFFFF);
    write_register(REG_ONSET_TH, 16'h7FFF);
    write_register(REG_OFFSET_TH, 16'h0000);
    write_register(REG_ONSET_N, 16'h00FF);
    write_register(REG_OFFSET_N, 16'h00FF);
    write_register(REG_RANGE, 16'h7FFF);
    write_register(REG_STABLE_MS, 16'hFFFF);
    queue_random(60);
    // Long receiver hold while commands keep coming, then a full sender pause.
    hold_cycles = 600;
    wait_drained();
    send_idle_pct = 59; recv_idle_pct = 13;

    write_register(REG_EMA_ALPHA, 16'd30000);
    write_register(REG_DAMPING, 16'd20000);
    write_register(REG_ONSET_TH, 16'd800);
    write_register(REG_OFFSET_TH, 16'd600);
    write_register(REG_ONSET_N, 16'd2);
    write_register(REG_OFFSET_N, 16'd3);
    write_register(REG_RANGE, 16'd3000);
    write_register(REG_STABLE_MS, 16'd5);
    for (int i = 0; i < 8; i++) queue_stroke();
    queue_random(150);
    send_pause = 1;
    while (expected_status.size() > 0 || in_valid_i) @(posedge clk_i);
    send_pause = 0;
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;

    write_register(REG_EMA_ALPHA, RST_EMA_ALPHA);
    write_register(REG_DAMPING, RST_DAMPING);
    write_register(REG_ONSET_TH, 16'(RST_ONSET_TH));
    write_register(REG_OFFSET_TH, 16'(RST_OFFSET_TH));
    write_register(REG_ONSET_N, 16'(RST_ONSET_N));
    write_register(REG_OFFSET_N, 16'(RST_OFFSET_N));
    write_register(REG_RANGE, 16'(RST_RANGE));
    write_register(REG_STABLE_MS, 16'd3);
    for (int i = 0; i < 4; i++) queue_stroke();
    queue_random(200);
    wait_drained();

    if (errors == 0) $display("[imu_stroke_grid_tracker_top] OK");
    else $display("[imu_stroke_grid_tracker_top] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[imu_stroke_grid_tracker_top] ERROR");
      $finish;
    end
  end
endmodule

@@ sim.f @@
+incdir+design
design/isgt_pkg.sv
design/isgt_ctrl.sv
design/isgt_dp.sv
design/imu_stroke_grid_tracker_top.sv
dv/imu_stroke_grid_tracker_top_test.sv
